// File: design/assert_macros.svh
// assertion macros used by the top level of the decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge while reset is released
`define ASSERT_CLKRST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/drp_pkg.sv
// types and constants of the detection row decoder
package drp_pkg;

    localparam int HEADER_LEN  = 5;
    localparam int MAX_CLASSES = 128;
    localparam int FRAC_BITS   = 12;

    // configuration register indexes
    localparam logic [2:0] REG_CONF_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_CLASS_COUNT    = 3'd1;
    localparam logic [2:0] REG_PAD_X          = 3'd2;
    localparam logic [2:0] REG_PAD_Y          = 3'd3;
    localparam logic [2:0] REG_SCALE_X        = 3'd4;
    localparam logic [2:0] REG_SCALE_Y        = 3'd5;

    typedef struct packed {
        logic [12:0] conf_threshold;
        logic [7:0]  class_count;
        logic [22:0] pad_x;
        logic [22:0] pad_y;
        logic [15:0] scale_x;
        logic [15:0] scale_y;
    } drp_cfg_t;

    // one finished row handed to the box math
    typedef struct packed {
        logic signed [26:0] nx;
        logic signed [26:0] ny;
        logic signed [23:0] w;
        logic signed [23:0] h;
        logic signed [23:0] obj;
        logic signed [23:0] best;
        logic [6:0]         cls;
    } drp_row_t;

    typedef struct packed {
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic signed [15:0] box_w;
        logic signed [15:0] box_h;
        logic [6:0]         class_id;
        logic [23:0]        confidence;
    } drp_box_t;

    // saturate a shifted pixel value to 16 bits signed
    function automatic logic signed [15:0] sat16(input logic signed [18:0] x);
        logic signed [15:0] r;
        if (x > 19'sd32767) begin
            r = 16'sh7fff;
        end else if (x < -19'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

// File: design/drp_accum.sv
// row accumulator: box field capture, running argmax and row check
module drp_accum (
    input  logic                aclk,
    input  logic                aresetn,
    input  drp_pkg::drp_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [23:0]  in_value,
    input  logic                in_end,
    output logic                row_valid,
    input  logic                row_ready,
    output drp_pkg::drp_row_t   row
);
    import drp_pkg::*;

    localparam logic [8:0] MAX_CLASSES_W = 9'(MAX_CLASSES);
    localparam logic [7:0] HEADER_W      = 8'(HEADER_LEN);

    logic [7:0]         pos_reg, pos_next;
    logic               overlong_reg, overlong_next;
    logic signed [23:0] box_reg [4];
    logic signed [23:0] obj_reg;
    logic signed [23:0] best_reg;
    logic [6:0]         cls_reg;
    logic               row_valid_reg, row_valid_next;
    drp_row_t           row_reg, row_next;

    logic               accept;
    logic [7:0]         cls_idx;
    logic               in_class;
    logic               better;
    logic signed [23:0] best_next;
    logic [6:0]         cls_next;
    logic               len_ok;
    logic               count_ok;
    logic               thr_ok;
    logic               keep;

    assign accept   = in_valid && in_ready;
    assign in_ready = !row_valid_reg || row_ready;

    // argmax over the class scores, first highest wins
    assign cls_idx   = pos_reg - HEADER_W;
    assign in_class  = (pos_reg >= HEADER_W) && (cls_idx < cfg.class_count) &&
                       ({1'b0, cls_idx} < MAX_CLASSES_W);
    assign better    = !overlong_reg && in_class && (in_value > best_reg);
    assign best_next = better ? in_value : best_reg;
    assign cls_next  = better ? cls_idx[6:0] : cls_reg;

    // row length and threshold checks at the row end
    assign len_ok   = ({1'b0, pos_reg} + 9'd1) == (9'(HEADER_LEN) + {1'b0, cfg.class_count});
    assign count_ok = (cfg.class_count != 8'd0) && ({1'b0, cfg.class_count} <= MAX_CLASSES_W);
    assign thr_ok   = ($signed({obj_reg[23], obj_reg}) >=
                       $signed({12'd0, cfg.conf_threshold})) &&
                      ($signed({best_next[23], best_next}) >
                       $signed({12'd0, cfg.conf_threshold}));
    assign keep     = !overlong_reg && count_ok && len_ok && thr_ok;

    // position counter and the overlong mark
    always_comb begin
        pos_next      = pos_reg;
        overlong_next = overlong_reg;
        if (accept) begin
            if (in_end) begin
                pos_next      = 8'd0;
                overlong_next = 1'b0;
            end else if (!overlong_reg) begin
                if (pos_reg == 8'hff) begin
                    overlong_next = 1'b1;
                end else begin
                    pos_next = pos_reg + 8'd1;
                end
            end
        end
    end

    // capture stage toward the box math
    always_comb begin
        row_valid_next = row_valid_reg;
        row_next       = row_reg;
        if (row_ready) begin
            row_valid_next = 1'b0;
        end
        if (accept && in_end && keep) begin
            row_valid_next = 1'b1;
            row_next.nx    = $signed({{2{box_reg[0][23]}}, box_reg[0], 1'b0})
                           - $signed({3'd0, cfg.pad_x, 1'b0})
                           - $signed({{3{box_reg[2][23]}}, box_reg[2]});
            row_next.ny    = $signed({{2{box_reg[1][23]}}, box_reg[1], 1'b0})
                           - $signed({3'd0, cfg.pad_y, 1'b0})
                           - $signed({{3{box_reg[3][23]}}, box_reg[3]});
            row_next.w     = box_reg[2];
            row_next.h     = box_reg[3];
            row_next.obj   = obj_reg;
            row_next.best  = best_next;
            row_next.cls   = cls_next;
        end
    end

    // per-row state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= 8'd0;
            overlong_reg <= 1'b0;
            box_reg[0]   <= '0;
            box_reg[1]   <= '0;
            box_reg[2]   <= '0;
            box_reg[3]   <= '0;
            obj_reg      <= '0;
            best_reg     <= '0;
            cls_reg      <= '0;
        end else begin
            pos_reg      <= pos_next;
            overlong_reg <= overlong_next;
            if (accept) begin
                if (in_end) begin
                    box_reg[0] <= '0;
                    box_reg[1] <= '0;
                    box_reg[2] <= '0;
                    box_reg[3] <= '0;
                    obj_reg    <= '0;
                    best_reg   <= '0;
                    cls_reg    <= '0;
                end else if (!overlong_reg) begin
                    if (pos_reg < 8'd4) begin
                        box_reg[pos_reg[1:0]] <= in_value;
                    end else if (pos_reg == 8'd4) begin
                        obj_reg <= in_value;
                    end
                    best_reg <= best_next;
                    cls_reg  <= cls_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= 1'b0;
        end else begin
            row_valid_reg <= row_valid_next;
        end
        row_reg <= row_next;
    end

    assign row_valid = row_valid_reg;
    assign row       = row_reg;

endmodule

// File: design/drp_box_math.sv
// box math: scale products, then truncation and saturation into the result register
module drp_box_math (
    input  logic                aclk,
    input  logic                aresetn,
    input  drp_pkg::drp_cfg_t   cfg,
    input  logic                row_valid,
    output logic                row_ready,
    input  drp_pkg::drp_row_t   row,
    output logic                res_valid,
    input  logic                res_ready,
    output drp_pkg::drp_box_t   res
);
    import drp_pkg::*;

    localparam logic signed [43:0] EDGE_BIAS = 44'sd33554431;
    localparam logic signed [40:0] SIZE_BIAS = 41'sd16777215;

    logic               prod_valid_reg, prod_valid_next;
    logic signed [43:0] px_reg, py_reg;
    logic signed [40:0] pw_reg, ph_reg;
    logic signed [47:0] pc_reg;
    logic [6:0]         pcls_reg;
    logic               res_valid_reg, res_valid_next;
    drp_box_t           res_reg, res_next;

    logic               prod_ready;
    logic               prod_load;
    logic signed [43:0] ex_sum, ey_sum;
    logic signed [40:0] sw_sum, sh_sum;
    logic signed [35:0] conf_q;

    assign prod_ready = !res_valid_reg || res_ready;
    assign row_ready  = !prod_valid_reg || prod_ready;
    assign prod_load  = row_valid && row_ready;

    // product stage
    always_comb begin
        prod_valid_next = prod_valid_reg;
        if (prod_ready) begin
            prod_valid_next = 1'b0;
        end
        if (prod_load) begin
            prod_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
        end
        if (prod_load) begin
            px_reg   <= row.nx * $signed({1'b0, cfg.scale_x});
            py_reg   <= row.ny * $signed({1'b0, cfg.scale_y});
            pw_reg   <= row.w * $signed({1'b0, cfg.scale_x});
            ph_reg   <= row.h * $signed({1'b0, cfg.scale_y});
            pc_reg   <= row.obj * row.best;
            pcls_reg <= row.cls;
        end
    end

    // truncation toward zero: bias negative products before the shift
    assign ex_sum = px_reg + (px_reg[43] ? EDGE_BIAS : 44'sd0);
    assign ey_sum = py_reg + (py_reg[43] ? EDGE_BIAS : 44'sd0);
    assign sw_sum = pw_reg + (pw_reg[40] ? SIZE_BIAS : 41'sd0);
    assign sh_sum = ph_reg + (ph_reg[40] ? SIZE_BIAS : 41'sd0);
    assign conf_q = pc_reg[47:FRAC_BITS];

    // result register
    always_comb begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_ready) begin
            res_valid_next = 1'b0;
        end
        if (prod_valid_reg && prod_ready) begin
            res_valid_next    = 1'b1;
            res_next.box_x    = sat16(ex_sum[43:25]);
            res_next.box_y    = sat16(ey_sum[43:25]);
            res_next.box_w    = sat16({{2{sw_sum[40]}}, sw_sum[40:24]});
            res_next.box_h    = sat16({{2{sh_sum[40]}}, sh_sum[40:24]});
            res_next.class_id = pcls_reg;
            if (conf_q[35]) begin
                res_next.confidence = 24'd0;
            end else if (|conf_q[34:24]) begin
                res_next.confidence = 24'hffffff;
            end else begin
                res_next.confidence = conf_q[23:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
        end
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: design/detection_row_decode.sv
// top level of the detection row decoder: config registers, accumulator and box math
//
// Detection rows stream in one element per transaction (center x, center y, width,
// height, objectness, then class_count class scores, s_tlast on the last one). One
// element is taken every cycle unless a captured row is stalled; the running argmax
// in the accumulator compares and updates on each accepted element. A row of the right
// length whose objectness and best score pass the threshold gives one box transaction,
// carried from its last element through a capture stage, a product stage with the
// scale multipliers and the result register with truncation and saturation. Rows that
// fail give nothing. There is no clearing pass after reset. Configuration writes are
// taken in any cycle but belong between rows, with no box still in flight.
`include "assert_macros.svh"

module detection_row_decode (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [22:0]  cfg_data,
    // row elements
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // value[23:0]
    input  logic         s_tlast,   // row_end
    // boxes
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata    // box_x, box_y, box_w, box_h, class_id, confidence, pad
);
    import drp_pkg::*;

    drp_cfg_t cfg_reg, cfg_next;
    logic     row_valid;
    logic     row_ready;
    drp_row_t row;
    drp_box_t res;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CONF_THRESHOLD: cfg_next.conf_threshold = cfg_data[12:0];
                REG_CLASS_COUNT:    cfg_next.class_count    = cfg_data[7:0];
                REG_PAD_X:          cfg_next.pad_x          = cfg_data;
                REG_PAD_Y:          cfg_next.pad_y          = cfg_data;
                REG_SCALE_X:        cfg_next.scale_x        = cfg_data[15:0];
                REG_SCALE_Y:        cfg_next.scale_y        = cfg_data[15:0];
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.conf_threshold <= 13'd2048;
            cfg_reg.class_count    <= 8'd80;
            cfg_reg.pad_x          <= 23'd0;
            cfg_reg.pad_y          <= 23'd0;
            cfg_reg.scale_x        <= 16'd4096;
            cfg_reg.scale_y        <= 16'd4096;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // row accumulation
    drp_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  ($signed(s_tdata)),
        .in_end    (s_tlast),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row       (row)
    );

    // box scaling and confidence
    drp_box_math u_box_math (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row       (row),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // result packing, lowest field first
    assign m_tdata = {1'b0, res.confidence, res.class_id,
                      res.box_h, res.box_w, res.box_y, res.box_x};

    // checks
    `ASSERT_CLK(a_no_result_after_reset, aclk, !aresetn |=> !m_tvalid, "result during reset")
    `ASSERT_CLKRST(a_row_from_last, aclk, aresetn, $rose(row_valid) |-> $past(s_tvalid && s_tready && s_tlast), "row captured without a last element")
    `ASSERT_CLKRST(a_row_holds, aclk, aresetn, (row_valid && !row_ready) |=> (row_valid && $stable(row)), "stalled row changed")

endmodule

// File: tb/testbench.sv
// self-checking testbench for the detection row decoder
`timescale 1ns / 100ps

module testbench;
    import drp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    typedef logic [23:0] row_t[$];

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = REG_CONF_THRESHOLD;
    logic [22:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;

    // register copies, reset values
    logic [12:0]  cfg_thr = 13'd2048;
    logic [7:0]   cfg_classes = 8'd80;
    logic [22:0]  cfg_pad_x = '0;
    logic [22:0]  cfg_pad_y = '0;
    logic [15:0]  cfg_scale_x = 16'd4096;
    logic [15:0]  cfg_scale_y = 16'd4096;

    // per-row decode state
    int unsigned        row_pos = 0;
    bit                 row_overlong = 1'b0;
    logic signed [23:0] row_cx = '0;
    logic signed [23:0] row_cy = '0;
    logic signed [23:0] row_w = '0;
    logic signed [23:0] row_h = '0;
    logic signed [23:0] row_obj = '0;
    logic signed [23:0] row_best = '0;
    logic [6:0]         row_cls = '0;

    drp_box_t boxes_due[$];
    int       mismatches = 0;
    int       items_sent = 0;
    int       send_idle_pct = 20;
    int       recv_idle_pct = 77;
    int       stall_len = 0;
    int       stall_req_id = 0;
    int       stall_seen_id = 0;
    int       stall_left = 0;
    int       cycle_count = 0;

    detection_row_decode dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // box receiver: random stalls plus requested long hold-offs
    always @(posedge aclk) begin
        if (stall_req_id != stall_seen_id) begin
            stall_seen_id = stall_req_id;
            stall_left = stall_len;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic signed [15:0] clamp16(input longint x);
        if (x > 32767) return 16'sh7fff;
        if (x < -32768) return -16'sh8000;
        return x[15:0];
    endfunction

    // left or top edge in pixels: (2c - 2pad - size) in 2^-13 units times a Q4.12 factor
    function automatic logic signed [15:0] edge_px(input logic signed [23:0] c,
                                                   input logic [22:0] pad,
                                                   input logic signed [23:0] size,
                                                   input logic [15:0] factor);
        longint n;
        n = 2 * longint'(c) - 2 * longint'(pad) - longint'(size);
        return clamp16((n * longint'(factor)) / (longint'(1) << 25));
    endfunction

    function automatic logic signed [15:0] size_px(input logic signed [23:0] size,
                                                   input logic [15:0] factor);
        return clamp16((longint'(size) * longint'(factor)) / (longint'(1) << 24));
    endfunction

    // advance the row decode by one element, queue a box at a passing row end
    function automatic void decode_element(input logic signed [23:0] v, input logic last);
        int unsigned pos;
        int unsigned cls_idx;
        bit          hit;
        longint      thr;
        longint      conf;
        drp_box_t    box;
        pos = row_pos;
        thr = longint'(cfg_thr);
        if (!row_overlong) begin
            case (pos)
                0: row_cx = v;
                1: row_cy = v;
                2: row_w = v;
                3: row_h = v;
                4: row_obj = v;
                default: begin
                    cls_idx = pos - HEADER_LEN;
                    if (cls_idx < cfg_classes && cls_idx < MAX_CLASSES && v > row_best) begin
                        row_best = v;
                        row_cls = cls_idx[6:0];
                    end
                end
            endcase
        end
        if (!last) begin
            if (!row_overlong) begin
                if (pos >= 255) row_overlong = 1'b1;
                else row_pos = pos + 1;
            end
            return;
        end
        hit = !row_overlong && cfg_classes >= 1 && cfg_classes <= MAX_CLASSES &&
              pos + 1 == HEADER_LEN + cfg_classes &&
              longint'(row_obj) >= thr && longint'(row_best) > thr;
        if (hit) begin
            conf = (longint'(row_obj) * longint'(row_best)) >>> FRAC_BITS;
            if (conf > 64'hFFFFFF) conf = 64'hFFFFFF;
            if (conf < 0) conf = 0;
            box.box_x = edge_px(row_cx, cfg_pad_x, row_w, cfg_scale_x);
            box.box_y = edge_px(row_cy, cfg_pad_y, row_h, cfg_scale_y);
            box.box_w = size_px(row_w, cfg_scale_x);
            box.box_h = size_px(row_h, cfg_scale_y);
            box.class_id = row_cls;
            box.confidence = conf[23:0];
            boxes_due = {boxes_due, box};
        end
        // every row end clears the row state
        row_pos = 0;
        row_overlong = 1'b0;
        row_cx = '0;
        row_cy = '0;
        row_w = '0;
        row_h = '0;
        row_obj = '0;
        row_best = '0;
        row_cls = '0;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    // compare each box transaction with the oldest pending box
    always @(posedge aclk) begin
        drp_box_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (boxes_due.size() == 0) begin
                mismatches++;
                $display("%0t: box transaction expected none got %h", $time, m_tdata);
            end else begin
                want = boxes_due.pop_front();
                check_field("box_x", $signed(want.box_x), $signed(m_tdata[15:0]));
                check_field("box_y", $signed(want.box_y), $signed(m_tdata[31:16]));
                check_field("box_w", $signed(want.box_w), $signed(m_tdata[47:32]));
                check_field("box_h", $signed(want.box_h), $signed(m_tdata[63:48]));
                check_field("class_id", want.class_id, m_tdata[70:64]);
                check_field("confidence", want.confidence, m_tdata[94:71]);
            end
        end
    end

    task automatic write_reg(input logic [2:0] index, input logic [22:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            REG_CONF_THRESHOLD: cfg_thr = data[12:0];
            REG_CLASS_COUNT:    cfg_classes = data[7:0];
            REG_PAD_X:          cfg_pad_x = data;
            REG_PAD_Y:          cfg_pad_y = data;
            REG_SCALE_X:        cfg_scale_x = data[15:0];
            REG_SCALE_Y:        cfg_scale_y = data[15:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setup(input int thr, input int classes, input int px, input int py,
                               input int fx, input int fy);
        write_reg(REG_CONF_THRESHOLD, 23'(thr));
        write_reg(REG_CLASS_COUNT, 23'(classes));
        write_reg(REG_PAD_X, 23'(px));
        write_reg(REG_PAD_Y, 23'(py));
        write_reg(REG_SCALE_X, 23'(fx));
        write_reg(REG_SCALE_Y, 23'(fy));
    endtask

    // stop offering, let every box arrive and the pipeline drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (boxes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_element(input logic [23:0] v, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        decode_element(v, last);
        items_sent++;
    endtask

    task automatic send_values(input row_t vals);
        for (int i = 0; i < vals.size(); i++)
            send_element(vals[i], i == vals.size() - 1);
    endtask

    function automatic logic [23:0] q12(input int px);
        return 24'(px * 4096);
    endfunction

    function automatic logic [23:0] rand_box_field();
        case ($urandom_range(2))
            0: return 24'($urandom());
            1: return 24'($urandom_range(24'h3FFFFF));
            default: return 24'(-$urandom_range(24'h0FFFFF));
        endcase
    endfunction

    // scores and objectness, weighted toward the threshold
    function automatic logic [23:0] rand_score();
        case ($urandom_range(4))
            0: return 24'($urandom());
            1: return 24'(cfg_thr + $urandom_range(4) - 2);
            2: return 24'($urandom_range(16383));
            3: return 24'(cfg_thr + 1 + $urandom_range(8192));
            default: return 24'(-$urandom_range(4096));
        endcase
    endfunction

    function automatic row_t build_row(input int len);
        row_t r;
        for (int i = 0; i < len; i++)
            r = {r, (i < 4) ? rand_box_field() : rand_score()};
        return r;
    endfunction

    task automatic random_setup();
        int thr;
        int classes;
        int px;
        int py;
        case ($urandom_range(3))
            0: thr = 0;
            1: thr = 4096;
            default: thr = $urandom_range(4096);
        endcase
        classes = ($urandom_range(9) == 0) ? 128 : $urandom_range(1, 8);
        case ($urandom_range(3))
            0: px = 0;
            1: px = 23'h7FFFFF;
            default: px = $urandom_range(23'h7FFFFF);
        endcase
        py = ($urandom_range(1) == 0) ? $urandom_range(23'h07FFFF) : $urandom_range(23'h7FFFFF);
        apply_setup(thr, classes, px, py,
                    ($urandom_range(4) == 0) ? 16'hFFFF : $urandom_range(16'hFFFF),
                    ($urandom_range(4) == 0) ? 0 : $urandom_range(16'hFFFF));
    endtask

    // argmax ties, extreme values and threshold boundaries, other registers at reset
    task automatic test_argmax_thresholds();
        row_t r;
        write_reg(REG_CLASS_COUNT, 23'd2);
        // equal scores: the first one wins
        r = '{q12(100), q12(50), q12(20), q12(10), q12(1), 24'd3000, 24'd3000};
        send_values(r);
        // extremes of the value field, a later class wins
        r = '{24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
              24'h800000, 24'h7FFFFF};
        send_values(r);
        // objectness equal to threshold passes, score just above passes
        r = '{q12(7), q12(9), q12(3), q12(5), 24'd2048, 24'd100, 24'd2049};
        send_values(r);
        // score equal to threshold fails
        r = '{q12(7), q12(9), q12(3), q12(5), 24'd4000, 24'd2048, 24'd2048};
        send_values(r);
        wait_idle();
    endtask

    // rows of the wrong length among well-formed ones, class counts out of range, overlong rows
    task automatic test_row_length();
        send_values(build_row(3));
        send_values(build_row(9));
        send_values(build_row(7));
        wait_idle();
        write_reg(REG_CLASS_COUNT, 23'd0);
        send_values(build_row(5));
        wait_idle();
        write_reg(REG_CLASS_COUNT, 23'd129);
        send_values(build_row(134));
        wait_idle();
        write_reg(REG_CLASS_COUNT, 23'd2);
        send_values(build_row(300));
        send_values(build_row(7));
        wait_idle();
    endtask

    // register extremes on both ends
    task automatic test_register_extremes();
        row_t r;
        apply_setup(4096, 128, 23'h7FFFFF, 23'h7FFFFF, 16'hFFFF, 16'h0000);
        r = build_row(133);
        r[4] = 24'h7FFFFF;
        r[132] = 24'h7FFFFF;
        send_values(r);
        wait_idle();
        apply_setup(0, 1, 0, 0, 16'h0000, 16'hFFFF);
        // no score above zero keeps class 0 at zero, which fails
        r = '{q12(30), q12(40), q12(8), q12(6), q12(1), 24'hFFF000};
        send_values(r);
        // zero objectness passes a zero threshold
        r = '{q12(30), q12(40), q12(8), q12(6), 24'd0, 24'd1};
        send_values(r);
        wait_idle();
    endtask

    task automatic test_random_rows(input int send_pct, input int recv_pct, input int n_items);
        int goal;
        int next_setup;
        int len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        goal = items_sent + n_items;
        next_setup = items_sent;
        while (items_sent < goal) begin
            if (items_sent >= next_setup) begin
                wait_idle();
                random_setup();
                next_setup = items_sent + 130;
            end
            len = HEADER_LEN + cfg_classes;
            // some broken rows among the well-formed ones
            if ($urandom_range(99) < 12) len = $urandom_range(1, HEADER_LEN + cfg_classes + 6);
            send_values(build_row(len));
        end
        wait_idle();
    endtask

    // receiver holds off while short passing rows keep coming
    task automatic test_backpressure();
        row_t r;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setup(0, 1, 0, 0, 4096, 4096);
        stall_len = 300;
        stall_req_id++;
        for (int i = 0; i < 30; i++) begin
            r = build_row(6);
            r[4] = 24'($urandom_range(1, 24'h7FFFFF));
            r[5] = 24'($urandom_range(1, 24'h7FFFFF));
            send_values(r);
        end
        wait_idle();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_argmax_thresholds();
        test_row_length();
        test_register_extremes();
        test_random_rows(20, 77, 100);
        test_random_rows(77, 20, 100);
        test_random_rows(0, 0, 100);
        test_backpressure();
        wait_idle();
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
